FILE: src/armc_pkg.sv
// Shared types and constants for the ramp meter controller.
`timescale 1ns / 1ps

package armc_pkg;

    // Field and state widths
    localparam int SUM_W  = 27;
    localparam int FLOW_W = 20;
    localparam int INT_W  = 16;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 3;

    // Shared divider geometry: quotient bits, divisor bits, step counter
    localparam int DIV_QW = 27;
    localparam int DIV_DW = 20;
    localparam int DIV_CW = 5;

    localparam logic [SUM_W-1:0]  SUM_MAX      = 27'd134217727;
    localparam logic [DIV_QW-1:0] INTERVAL_NUM = 27'd9216000;

    // Reset values of configuration and state
    localparam logic [15:0]       GAIN_RST     = 16'd17920;
    localparam logic [14:0]       TARGET_RST   = 15'd5120;
    localparam logic [11:0]       FLOW_MIN_RST = 12'd200;
    localparam logic [11:0]       FLOW_MAX_RST = 12'd1800;
    localparam logic [4:0]        LANES_RST    = 5'd2;
    localparam logic [7:0]        PERIOD_RST   = 8'd30;
    localparam logic [FLOW_W-1:0] FLOW_RST     = 20'd76800;
    localparam logic [INT_W-1:0]  INTERVAL_RST = 16'd150;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_GAIN     = 3'd0;
    localparam logic [IDX_W-1:0] REG_TARGET   = 3'd1;
    localparam logic [IDX_W-1:0] REG_FLOW_MIN = 3'd2;
    localparam logic [IDX_W-1:0] REG_FLOW_MAX = 3'd3;
    localparam logic [IDX_W-1:0] REG_LANES    = 3'd4;
    localparam logic [IDX_W-1:0] REG_PERIOD   = 3'd5;

    typedef enum logic [1:0] {
        OP_SAMPLE   = 2'd0,
        OP_UPDATE   = 2'd1,
        OP_TICK     = 2'd2,
        OP_OVERRIDE = 2'd3
    } op_t;

    typedef struct packed {
        logic              start;
        logic [DIV_QW-1:0] numer;
        logic [DIV_DW-1:0] denom;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_QW-1:0] quot;
    } div_rsp_t;

endpackage

FILE: src/armc_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module armc_div
    import armc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic [DIV_DW-1:0] rem_reg, rem_next;
    logic [DIV_QW-1:0] quot_reg, quot_next;
    logic [DIV_DW-1:0] den_reg, den_next;

    logic [DIV_DW:0]   trial;
    logic [DIV_DW:0]   trial_sub;
    logic              ge;

    always_comb
    begin
        trial     = {rem_reg, quot_reg[DIV_QW-1]};
        trial_sub = trial - {1'b0, den_reg};
        ge        = (trial >= {1'b0, den_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        den_next  = den_reg;

        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CW'(DIV_QW - 1);
            rem_next  = '0;
            quot_next = req.numer;
            den_next  = req.denom;
        end
        else if (busy_reg)
        begin
            // shift in one numerator bit, subtract when it fits
            rem_next  = ge ? trial_sub[DIV_DW-1:0] : trial[DIV_DW-1:0];
            quot_next = {quot_reg[DIV_QW-2:0], ge};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        den_reg  <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

FILE: src/alinea_ramp_meter_controller_unit.sv
// Top level of the ALINEA ramp meter controller.
`timescale 1ns / 1ps
// Sample, tick and override items are registered into the output at the accepting edge (result
// shown in the next cycle) when the output register is free, else they are parked in S_HOLD; one
// item per cycle is taken while the output register drains. An update item makes two passes
// through the shared 27-step restoring divider (mean occupancy, then green interval) with sequencing,
// multiply, rounding and clamping; in_ready stays low until its result is loaded into the output.
// Reset (asynchronous, active low) loads the default configuration, 300 veh/h flow,
// a 150-tick interval, and clears the accumulator, the tick counter and the output register.

module alinea_ramp_meter_controller_unit
    import armc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration write port
    input  logic              cfg_wr_en,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    // input item channel
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        op,
    input  logic [14:0]       occupancy_sample,
    input  logic [INT_W-1:0]  override_interval,
    // result item channel
    output logic              out_valid,
    input  logic              out_ready,
    output logic              green_pulse,
    output logic [FLOW_W-1:0] metered_flow,
    output logic [INT_W-1:0]  green_interval
);

    typedef enum logic [2:0] {
        S_IDLE,   // take items; quick ops complete here when the output is free
        S_MEAN,   // wait for occupancy_sum / (lanes * period)
        S_MUL,    // gain * (target - mean)
        S_DELTA,  // scale product to Q.8 step, truncating toward zero
        S_FLOW,   // add step and clamp
        S_RECIP,  // launch 9216000 / flow
        S_INTV,   // wait for interval, saturate, clear accumulator
        S_HOLD    // wait for the output register to free up
    } state_t;

    // Configuration registers
    logic [15:0] gain_reg;
    logic [14:0] target_reg;
    logic [11:0] flow_min_reg;
    logic [11:0] flow_max_reg;
    logic [4:0]  lanes_reg;
    logic [7:0]  period_reg;

    // Controller state
    state_t             state_reg, state_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [FLOW_W-1:0]  flow_reg, flow_next;
    logic [INT_W-1:0]   interval_reg, interval_next;
    logic [INT_W-1:0]   tick_reg, tick_next;
    logic               pend_pulse_reg, pend_pulse_next;

    // Update datapath
    logic signed [27:0] diff_reg, diff_next;
    logic signed [44:0] prod_reg, prod_next;
    logic signed [36:0] delta_reg, delta_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic               out_pulse_reg, out_pulse_next;
    logic [FLOW_W-1:0]  out_flow_reg, out_flow_next;
    logic [INT_W-1:0]   out_interval_reg, out_interval_next;

    // Shared divider
    div_req_t div_req;
    div_rsp_t div_rsp;

    logic               accept;
    logic               out_free;
    logic               pulse;
    logic               load_out;
    logic [4:0]         lanes_eff;
    logic [7:0]         period_eff;
    logic [12:0]        divisor;
    logic [SUM_W:0]     sum_add;
    logic [INT_W:0]     tick_inc;
    logic signed [44:0] prod_adj;
    logic signed [37:0] flow_sum;
    logic signed [37:0] hi_bound;
    logic signed [37:0] lo_bound;
    logic               delta_pos;

    armc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_ready       = (state_reg == S_IDLE);
    assign accept         = in_valid && in_ready;
    assign out_free       = !out_valid_reg || out_ready;
    assign out_valid      = out_valid_reg;
    assign green_pulse    = out_pulse_reg;
    assign metered_flow   = out_flow_reg;
    assign green_interval = out_interval_reg;

    // A lane count or period of zero acts as one in the divisor
    assign lanes_eff  = (lanes_reg == '0) ? 5'd1 : lanes_reg;
    assign period_eff = (period_reg == '0) ? 8'd1 : period_reg;
    assign divisor    = lanes_eff * period_eff;

    always_comb
    begin
        sum_add   = {1'b0, sum_reg} + {13'd0, occupancy_sample};
        tick_inc  = {1'b0, tick_reg} + 1'b1;
        // bias negative products so the shift truncates toward zero
        prod_adj  = prod_reg + $signed({37'd0, prod_reg[44] ? 8'hFF : 8'h00});
        flow_sum  = $signed({18'd0, flow_reg}) + 38'(delta_reg);
        hi_bound  = $signed({18'd0, flow_max_reg, 8'd0});
        lo_bound  = $signed({18'd0, flow_min_reg, 8'd0});
        delta_pos = !delta_reg[36] && (delta_reg != '0);

        state_next      = state_reg;
        sum_next        = sum_reg;
        flow_next       = flow_reg;
        interval_next   = interval_reg;
        tick_next       = tick_reg;
        pend_pulse_next = pend_pulse_reg;
        diff_next       = diff_reg;
        prod_next       = prod_reg;
        delta_next      = delta_reg;
        pulse           = 1'b0;
        load_out        = 1'b0;

        div_req.start = 1'b0;
        div_req.numer = sum_reg;
        div_req.denom = {7'd0, divisor};

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (op_t'(op))
                        OP_SAMPLE:
                        begin
                            // saturate the accumulator
                            sum_next = (sum_add > {1'b0, SUM_MAX}) ? SUM_MAX
                                                                   : sum_add[SUM_W-1:0];
                        end
                        OP_UPDATE:
                        begin
                            div_req.start = 1'b1;
                            state_next    = S_MEAN;
                        end
                        OP_TICK:
                        begin
                            if (tick_inc >= {1'b0, interval_reg})
                            begin
                                pulse     = 1'b1;
                                tick_next = '0;
                            end
                            else
                            begin
                                tick_next = tick_inc[INT_W-1:0];
                            end
                        end
                        OP_OVERRIDE:
                        begin
                            interval_next = override_interval;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase

                    if (op_t'(op) != OP_UPDATE)
                    begin
                        // finish now if the output register can take it, else park
                        if (out_free)
                        begin
                            load_out = 1'b1;
                        end
                        else
                        begin
                            pend_pulse_next = pulse;
                            state_next      = S_HOLD;
                        end
                    end
                end
            end
            S_MEAN:
            begin
                if (div_rsp.done)
                begin
                    diff_next  = $signed({13'd0, target_reg}) - $signed({1'b0, div_rsp.quot});
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next  = $signed({1'b0, gain_reg}) * diff_reg;
                state_next = S_DELTA;
            end
            S_DELTA:
            begin
                delta_next = prod_adj[44:8];
                state_next = S_FLOW;
            end
            S_FLOW:
            begin
                // a positive step clamps at the top, any other at the bottom
                if (delta_pos)
                begin
                    flow_next = (flow_sum > hi_bound) ? hi_bound[FLOW_W-1:0]
                                                      : flow_sum[FLOW_W-1:0];
                end
                else
                begin
                    flow_next = (flow_sum < lo_bound) ? lo_bound[FLOW_W-1:0]
                                                      : flow_sum[FLOW_W-1:0];
                end
                state_next = S_RECIP;
            end
            S_RECIP:
            begin
                // zero flow gives an all-ones quotient, which saturates below
                div_req.start = 1'b1;
                div_req.numer = INTERVAL_NUM;
                div_req.denom = flow_reg;
                state_next    = S_INTV;
            end
            S_INTV:
            begin
                if (div_rsp.done)
                begin
                    interval_next   = (div_rsp.quot[DIV_QW-1:INT_W] != '0) ? '1
                                                            : div_rsp.quot[INT_W-1:0];
                    sum_next        = '0;
                    pend_pulse_next = 1'b0;
                    state_next      = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    pulse      = pend_pulse_reg;
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // output register: drop on handshake, load with post-item state
        out_valid_next    = out_valid_reg && !out_ready;
        out_pulse_next    = out_pulse_reg;
        out_flow_next     = out_flow_reg;
        out_interval_next = out_interval_reg;
        if (load_out)
        begin
            out_valid_next    = 1'b1;
            out_pulse_next    = pulse;
            out_flow_next     = flow_next;
            out_interval_next = interval_next;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg     <= GAIN_RST;
            target_reg   <= TARGET_RST;
            flow_min_reg <= FLOW_MIN_RST;
            flow_max_reg <= FLOW_MAX_RST;
            lanes_reg    <= LANES_RST;
            period_reg   <= PERIOD_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_GAIN:     gain_reg     <= cfg_data;
                REG_TARGET:   target_reg   <= cfg_data[14:0];
                REG_FLOW_MIN: flow_min_reg <= cfg_data[11:0];
                REG_FLOW_MAX: flow_max_reg <= cfg_data[11:0];
                REG_LANES:    lanes_reg    <= cfg_data[4:0];
                REG_PERIOD:   period_reg   <= cfg_data[7:0];
                default:      gain_reg     <= gain_reg;
            endcase
        end
    end

    // Sequencer state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            sum_reg          <= '0;
            flow_reg         <= FLOW_RST;
            interval_reg     <= INTERVAL_RST;
            tick_reg         <= '0;
            pend_pulse_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_pulse_reg    <= 1'b0;
            out_flow_reg     <= '0;
            out_interval_reg <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            sum_reg          <= sum_next;
            flow_reg         <= flow_next;
            interval_reg     <= interval_next;
            tick_reg         <= tick_next;
            pend_pulse_reg   <= pend_pulse_next;
            out_valid_reg    <= out_valid_next;
            out_pulse_reg    <= out_pulse_next;
            out_flow_reg     <= out_flow_next;
            out_interval_reg <= out_interval_next;
        end
    end

    // Update datapath payload
    always_ff @(posedge clk)
    begin
        diff_reg  <= diff_next;
        prod_reg  <= prod_next;
        delta_reg <= delta_next;
    end

endmodule

FILE: src/armc_checker.sv
// Port-level checks for the ramp meter controller, bound to the top level.
`timescale 1ns / 1ps

module armc_checker
    import armc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic [1:0]        op,
    input logic [INT_W-1:0]  override_interval,
    input logic              out_valid,
    input logic              out_ready,
    input logic              green_pulse,
    input logic [FLOW_W-1:0] metered_flow,
    input logic [INT_W-1:0]  green_interval
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(green_pulse)
            && $stable(metered_flow) && $stable(green_interval))
        else $error("stalled result changed");

    // an update item blocks the input while the regulator runs
    a_update_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (op == OP_UPDATE) |=> !in_ready)
        else $error("input ready during regulator update");

    // quick items produce a result at once when the output is free
    a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (op != OP_UPDATE) && (!out_valid || out_ready)
            |=> out_valid)
        else $error("quick item gave no result");

    // an override shows its interval and no pulse
    a_override: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (op == OP_OVERRIDE) && (!out_valid || out_ready)
            |=> !green_pulse && (green_interval == $past(override_interval)))
        else $error("override result wrong");

endmodule

bind alinea_ramp_meter_controller_unit armc_checker u_armc_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .op                (op),
    .override_interval (override_interval),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .green_pulse       (green_pulse),
    .metered_flow      (metered_flow),
    .green_interval    (green_interval)
);

FILE: verif/tb_top.sv
// Self-checking testbench for the ramp meter controller: flow predictor and stimulus.
`timescale 1ns / 1ps

import armc_pkg::*;

// One result item as the controller should report it
typedef struct {
    logic              pulse;
    logic [FLOW_W-1:0] flow;
    logic [INT_W-1:0]  interval;
} meter_reading_t;

// Tracks the meter's registers and state, and holds the readings still owed by the block
class ramp_meter_predictor;
    logic [15:0]       gain;
    logic [14:0]       target;
    logic [11:0]       flow_min;
    logic [11:0]       flow_max;
    logic [4:0]        lanes;
    logic [7:0]        period;
    logic [SUM_W-1:0]  occ_sum;
    logic [FLOW_W-1:0] flow;
    logic [INT_W-1:0]  interval;
    logic [INT_W-1:0]  ticks;
    meter_reading_t    expected_readings[$];
    int                errors;

    function new();
        gain     = GAIN_RST;
        target   = TARGET_RST;
        flow_min = FLOW_MIN_RST;
        flow_max = FLOW_MAX_RST;
        lanes    = LANES_RST;
        period   = PERIOD_RST;
        occ_sum  = '0;
        flow     = FLOW_RST;
        interval = INTERVAL_RST;
        ticks    = '0;
        errors   = 0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        case (idx)
            REG_GAIN:     gain     = data;
            REG_TARGET:   target   = data[14:0];
            REG_FLOW_MIN: flow_min = data[11:0];
            REG_FLOW_MAX: flow_max = data[11:0];
            REG_LANES:    lanes    = data[4:0];
            REG_PERIOD:   period   = data[7:0];
            default:      ;
        endcase
    endfunction

    function int pending();
        return expected_readings.size();
    endfunction

    // Advance the state by one accepted item and queue the reading it must produce
    function void accept_item(op_t code, logic [14:0] occ, logic [INT_W-1:0] over);
        longint         sum_next;
        longint         divisor;
        longint         mean;
        longint         delta_q8;
        longint         level;
        longint         quot;
        meter_reading_t r;
        r.pulse = 1'b0;
        case (code)
            OP_SAMPLE:
            begin
                sum_next = longint'(occ_sum) + longint'(occ);
                occ_sum  = (sum_next > longint'(SUM_MAX)) ? SUM_MAX : sum_next[SUM_W-1:0];
            end
            OP_UPDATE:
            begin
                divisor = longint'(lanes == 0 ? 5'd1 : lanes)
                        * longint'(period == 0 ? 8'd1 : period);
                mean    = longint'(occ_sum) / divisor;
                // gain is Q8.8: drop the fraction, truncating toward zero
                delta_q8 = longint'(gain) * (longint'(target) - mean) / 256;
                level    = longint'(flow) + delta_q8;
                if (delta_q8 > 0)
                begin
                    if (level > longint'(flow_max) * 256)
                        level = longint'(flow_max) * 256;
                end
                else if (level < longint'(flow_min) * 256)
                begin
                    level = longint'(flow_min) * 256;
                end
                flow = level[FLOW_W-1:0];
                if (flow == '0)
                    interval = '1;
                else
                begin
                    quot     = longint'(INTERVAL_NUM) / longint'(flow);
                    interval = (quot > longint'({INT_W{1'b1}})) ? '1 : quot[INT_W-1:0];
                end
                occ_sum = '0;
            end
            OP_TICK:
            begin
                if (longint'(ticks) + 1 >= longint'(interval))
                begin
                    r.pulse = 1'b1;
                    ticks   = '0;
                end
                else
                    ticks = ticks + 1'b1;
            end
            default: interval = over;
        endcase
        r.flow     = flow;
        r.interval = interval;
        expected_readings.push_back(r);
    endfunction

    function void check_reading(logic pulse, logic [FLOW_W-1:0] flw, logic [INT_W-1:0] intv);
        meter_reading_t want;
        if (expected_readings.size() == 0)
        begin
            $error("result item with none pending: pulse %0d flow %0d interval %0d",
                   pulse, flw, intv);
            errors++;
            return;
        end
        want = expected_readings.pop_front();
        if (want.pulse !== pulse)
        begin
            $error("green_pulse: expected %0d, got %0d", want.pulse, pulse);
            errors++;
        end
        if (want.flow !== flw)
        begin
            $error("metered_flow: expected %0d, got %0d", want.flow, flw);
            errors++;
        end
        if (want.interval !== intv)
        begin
            $error("green_interval: expected %0d, got %0d", want.interval, intv);
            errors++;
        end
    endfunction
endclass

module tb_top;

    localparam int CLK_PERIOD = 12;
    // Longest stretch without any handshake before the run is declared hung. The worst
    // legitimate gap is the receiver hold-off below plus one update.
    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AFTER = 700;
    localparam int ITEMS_PER_PHASE = 240;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]  cfg_data;
    logic              in_valid;
    logic              in_ready;
    logic [1:0]        op;
    logic [14:0]       occupancy_sample;
    logic [INT_W-1:0]  override_interval;
    logic              out_valid;
    logic              out_ready;
    logic              green_pulse;
    logic [FLOW_W-1:0] metered_flow;
    logic [INT_W-1:0]  green_interval;

    ramp_meter_predictor meter = new();

    bit steady = 1'b0;     // set: neither side idles
    int items_sent = 0;
    int results_seen = 0;
    int idle_cycles = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    alinea_ramp_meter_controller_unit u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .op               (op),
        .occupancy_sample (occupancy_sample),
        .override_interval(override_interval),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .green_pulse      (green_pulse),
        .metered_flow     (metered_flow),
        .green_interval   (green_interval)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Monitor both channels at the edge where an item moves. Values read here are the
    // ones the block sampled, since all drivers update with nonblocking assignments.
    // Also watch for a hung block: too long without any item moving ends the run.
    always @(posedge clk)
    begin
        if (in_valid === 1'b1 && in_ready === 1'b1)
            meter.accept_item(op_t'(op), occupancy_sample, override_interval);
        if (out_valid === 1'b1 && out_ready === 1'b1)
        begin
            meter.check_reading(green_pulse, metered_flow, green_interval);
            results_seen++;
        end
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Result side: take results with random stalls, except for one long hold-off that
    // lets the output back up and stall the input while the sender keeps offering.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else if (!hold_done && results_seen >= HOLD_AFTER)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= steady || ($urandom_range(0, 99) >= 10);
    end

    // Filler for fields the op ignores
    function automatic logic [14:0] any_sample();
        return 15'($urandom_range(0, 25600));
    endfunction

    function automatic logic [INT_W-1:0] any_interval();
        return INT_W'($urandom_range(1, 36000));
    endfunction

    // Mostly short intervals so that ticks actually reach a green
    function automatic logic [INT_W-1:0] pick_interval();
        if ($urandom_range(0, 9) < 7)
            return INT_W'($urandom_range(1, 40));
        return any_interval();
    endfunction

    // Samples clustered around the target half the time, so regulator steps go both ways
    function automatic logic [14:0] near_target();
        int centre;
        int v;
        centre = $urandom_range(0, 1) ? int'(meter.target) : int'($urandom_range(0, 25600));
        v = centre + int'($urandom_range(0, 4096)) - 2048;
        if (v < 0)
            v = 0;
        if (v > 25600)
            v = 25600;
        return v[14:0];
    endfunction

    // Offer one item and hold it until accepted; maybe idle a little first
    task automatic send_item(op_t code, logic [14:0] occ, logic [INT_W-1:0] over);
        if (!steady && $urandom_range(0, 99) < 10)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid          <= 1'b1;
        op                <= code;
        occupancy_sample  <= occ;
        override_interval <= over;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        items_sent++;
    endtask

    // Drop valid and wait until every owed result item has come back
    task automatic settle();
        in_valid <= 1'b0;
        while (results_seen != items_sent)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write all six registers, one per cycle; only call with the block idle
    task automatic apply_config(logic [CFG_W-1:0] g, logic [CFG_W-1:0] t,
                                logic [CFG_W-1:0] fmin, logic [CFG_W-1:0] fmax,
                                logic [CFG_W-1:0] nl, logic [CFG_W-1:0] per);
        logic [IDX_W-1:0] idx [6] = '{REG_GAIN, REG_TARGET, REG_FLOW_MIN,
                                      REG_FLOW_MAX, REG_LANES, REG_PERIOD};
        logic [CFG_W-1:0] vals [6];
        vals = '{g, t, fmin, fmax, nl, per};
        for (int i = 0; i < 6; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            meter.set_reg(idx[i], vals[i]);
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Random traffic: mostly measurement windows (samples, a full window only when lanes * period
    // is at most 48, then an update) with ticks mixed in, the rest single items of any op or runs of ticks
    task automatic run_mix(int count);
        int   start;
        int   divisor;
        int   span;
        op_t  code;
        start   = items_sent;
        divisor = int'(meter.lanes == 0 ? 5'd1 : meter.lanes)
                * int'(meter.period == 0 ? 8'd1 : meter.period);
        while (items_sent - start < count)
        begin
            if ($urandom_range(0, 9) < 6)
            begin
                span = (divisor <= 48) ? divisor : int'($urandom_range(1, 48));
                repeat (span)
                begin
                    if ($urandom_range(0, 9) == 0)
                        send_item(OP_TICK, any_sample(), any_interval());
                    send_item(OP_SAMPLE, near_target(), any_interval());
                end
                send_item(OP_UPDATE, any_sample(), any_interval());
            end
            else
            begin
                code = op_t'($urandom_range(0, 3));
                if (code == OP_TICK)
                    repeat ($urandom_range(1, 20)) send_item(OP_TICK, any_sample(), any_interval());
                else if (code == OP_OVERRIDE)
                    send_item(OP_OVERRIDE, any_sample(), pick_interval());
                else
                    send_item(code, near_target(), any_interval());
            end
        end
    endtask

    initial
    begin
        int fmin;

        // Hold every input at a known value, then pulse reset
        rst_n             <= 1'b0;
        cfg_wr_en         <= 1'b0;
        cfg_index         <= REG_GAIN;
        cfg_data          <= '0;
        in_valid          <= 1'b0;
        op                <= OP_SAMPLE;
        occupancy_sample  <= '0;
        override_interval <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items at reset configuration: field extremes, every op, and the tick
        // cases (interval of one, interval of zero, override below the running count).
        send_item(OP_TICK, any_sample(), any_interval());
        send_item(OP_SAMPLE, 15'd0, any_interval());
        send_item(OP_SAMPLE, 15'd25600, any_interval());
        send_item(OP_SAMPLE, 15'd16384, any_interval());
        send_item(OP_SAMPLE, 15'd16383, any_interval());
        send_item(OP_UPDATE, any_sample(), any_interval());
        send_item(OP_OVERRIDE, any_sample(), 16'd36000);
        send_item(OP_OVERRIDE, any_sample(), 16'd32767);
        send_item(OP_OVERRIDE, any_sample(), 16'd1);
        send_item(OP_TICK, any_sample(), any_interval());
        send_item(OP_OVERRIDE, any_sample(), 16'd0);
        send_item(OP_TICK, any_sample(), any_interval());
        send_item(OP_OVERRIDE, any_sample(), 16'd200);
        repeat (10) send_item(OP_TICK, any_sample(), any_interval());
        send_item(OP_OVERRIDE, any_sample(), 16'd3);
        send_item(OP_TICK, any_sample(), any_interval());
        send_item(OP_UPDATE, any_sample(), any_interval());
        settle();

        // Zero gain gives a zero step, which takes the lower clamp: flow rises to flow_min
        apply_config(16'd0, 16'd5120, 16'd4000, 16'd4000, 16'd2, 16'd30);
        send_item(OP_UPDATE, any_sample(), any_interval());
        settle();

        // Positive step from a flow above flow_max: drop to flow_max
        apply_config(16'hFFFF, 16'd25600, 16'd1, 16'd100, 16'd2, 16'd30);
        send_item(OP_UPDATE, any_sample(), any_interval());
        settle();

        // Zero lanes and zero period divide by one; a floor of zero lets flow reach zero,
        // which saturates the interval
        apply_config(16'hFFFF, 16'd0, 16'd0, 16'd4000, 16'd0, 16'd0);
        repeat (3) send_item(OP_SAMPLE, 15'd25600, any_interval());
        send_item(OP_UPDATE, any_sample(), any_interval());
        repeat (2) send_item(OP_TICK, any_sample(), any_interval());
        settle();

        // A run of full-scale samples gives a large negative step down to the floor
        apply_config(16'd17920, 16'd5120, 16'd1, 16'd4000, 16'd1, 16'd1);
        repeat (60) send_item(OP_SAMPLE, 15'd25600, any_interval());
        send_item(OP_UPDATE, any_sample(), any_interval());
        settle();

        // Small nonzero flow: quotient overflows 16 bits and the interval saturates
        apply_config(16'd256, 16'd0, 16'd0, 16'd4000, 16'd1, 16'd1);
        send_item(OP_SAMPLE, 15'd156, any_interval());
        send_item(OP_UPDATE, any_sample(), any_interval());
        settle();

        // Random phases: two at the register extremes, the rest random; one phase runs
        // with no idling on either side, and the receiver hold-off lands in a random one
        for (int p = 0; p < 6; p++)
        begin
            if (p == 0)
                apply_config(16'hFFFF, 16'd25600, 16'd4000, 16'd4000, 16'd16, 16'd255);
            else if (p == 1)
                apply_config(16'd0, 16'd0, 16'd1, 16'd1, 16'd1, 16'd1);
            else
            begin
                fmin = $urandom_range(1, 4000);
                apply_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 25600)),
                             16'(fmin), 16'($urandom_range(fmin, 4000)),
                             16'($urandom_range(1, 6)), 16'($urandom_range(1, 10)));
            end
            steady = (p == 3);
            run_mix(ITEMS_PER_PHASE);
            steady = 1'b0;
            settle();
        end

        // Let any stray result item show up before the verdict
        repeat (100) @(posedge clk);
        if (meter.errors == 0 && meter.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
